// ----- rtl/mexp_pkg.sv -----
// Shared types for the modular exponentiation unit: command and status between controller and datapath.
`default_nettype none

package mexp_pkg;

	typedef enum logic {
		SEL_SQUARE,
		SEL_MULT
	} opsel_t;

	typedef struct packed {
		logic   load;
		logic   start;
		opsel_t sel;
		logic   step;
		logic   wb_base;
		logic   wb_acc;
		logic   exp_shift;
		logic   out_load;
	} cmd_t;

	typedef struct packed {
		logic exp_bit;
	} status_t;

endpackage

`default_nettype wire

// ----- rtl/mexp_if.sv -----
// Valid/ready channel interfaces for operand items and result items.
`default_nettype none

interface mexp_in_if #(
	parameter int OPERAND_BITS = 31
) ();
	logic                    valid;
	logic                    ready;
	logic [OPERAND_BITS-1:0] base;
	logic [OPERAND_BITS-1:0] exponent;

	modport source (output valid, output base, output exponent, input ready);
	modport sink   (input valid, input base, input exponent, output ready);
endinterface

interface mexp_out_if #(
	parameter int OPERAND_BITS = 31
) ();
	logic                    valid;
	logic                    ready;
	logic [OPERAND_BITS-1:0] power_mod;

	modport source (output valid, output power_mod, input ready);
	modport sink   (input valid, input power_mod, output ready);
endinterface

`default_nettype wire

// ----- rtl/modular_exponentiation_unit.sv -----
// Top level of the modular exponentiation unit: base to the power exponent modulo a set modulus.
// Usage:
//   operands : sink channel carrying base and exponent; an item is taken when valid and
//              ready are both high. ready is high only while no item is in progress.
//   result   : source channel carrying power_mod, held in an output register until taken.
//   cfg_we / cfg_data : write the modulus; write it only while the unit is idle.
// Timing: the exponent is scanned from its top bit by square-and-multiply, and every
//   modular product runs through one shared shift-and-add multiplier, one multiplier bit
//   per cycle; each squaring and multiplication begins with a start state that loads its
//   operands. The base is first reduced by the same multiplier. One item is in progress
//   at a time; the next item can be taken at the earliest in the cycle in which the
//   result goes valid.
// Reset: arst_n clears the controller, drops result valid and sets the modulus to 2.
// Stall: a new item may be taken while a finished result waits; if that item finishes
//   while the result is still not taken, it holds until the output register frees.
// Modulus below 2 gives power_mod 0; exponent zero gives 1.
`default_nettype none

module modular_exponentiation_unit #(
	parameter int OPERAND_BITS = 31
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	mexp_in_if.sink                      operands,
	mexp_out_if.source                   result,
	input  wire logic                    cfg_we,
	input  wire logic [OPERAND_BITS-1:0] cfg_data
);

	mexp_pkg::cmd_t    cmd;
	mexp_pkg::status_t status;

	mexp_ctrl #(
		.OPERAND_BITS(OPERAND_BITS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (operands.valid),
		.in_ready (operands.ready),
		.out_valid(result.valid),
		.out_ready(result.ready),
		.status   (status),
		.cmd      (cmd)
	);

	mexp_datapath #(
		.OPERAND_BITS(OPERAND_BITS)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_data   (cfg_data),
		.in_base    (operands.base),
		.in_exponent(operands.exponent),
		.cmd        (cmd),
		.status     (status),
		.power_mod  (result.power_mod)
	);

endmodule

`default_nettype wire

// ----- rtl/mexp_datapath.sv -----
// Datapath: modulus register, exponent shifter, accumulator and bit-serial modular multiplier.
`default_nettype none

module mexp_datapath #(
	parameter int OPERAND_BITS = 31
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    cfg_we,
	input  wire logic [OPERAND_BITS-1:0] cfg_data,
	input  wire logic [OPERAND_BITS-1:0] in_base,
	input  wire logic [OPERAND_BITS-1:0] in_exponent,
	input  wire mexp_pkg::cmd_t          cmd,
	output mexp_pkg::status_t            status,
	output logic [OPERAND_BITS-1:0]      power_mod
);

	localparam int N = OPERAND_BITS;

	logic [N-1:0] modulus_q;
	logic [N-1:0] base_q;
	logic [N-1:0] exp_q;
	logic [N-1:0] acc_q;
	logic [N-1:0] ma_q;
	logic [N-1:0] mb_q;
	logic [N-1:0] pacc_q;
	logic [N-1:0] res_q;

	logic [N-1:0] addend;
	logic [N+1:0] sum;
	logic [N+1:0] mod_x1;
	logic [N+1:0] mod_x2;
	logic [N+1:0] red;
	logic [N-1:0] pacc_next;
	logic         mod_small;

	// 2*pacc + bit*a stays below three times the modulus
	always_comb begin
		addend = mb_q[N-1] ? ma_q : '0;
		sum    = {1'b0, pacc_q, 1'b0} + {2'b00, addend};
		mod_x1 = {2'b00, modulus_q};
		mod_x2 = {1'b0, modulus_q, 1'b0};
		if (sum >= mod_x2) begin
			red = sum - mod_x2;
		end else if (sum >= mod_x1) begin
			red = sum - mod_x1;
		end else begin
			red = sum;
		end
		pacc_next = red[N-1:0];
	end

	assign mod_small = (modulus_q[N-1:1] == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q <= N'(2);
		end else if (cfg_we) begin
			modulus_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			exp_q  <= in_exponent;
			acc_q  <= N'(1);
			ma_q   <= N'(1);
			mb_q   <= in_base;
			pacc_q <= '0;
		end else if (cmd.start) begin
			ma_q   <= acc_q;
			mb_q   <= (cmd.sel == mexp_pkg::SEL_MULT) ? base_q : acc_q;
			pacc_q <= '0;
		end else if (cmd.step) begin
			pacc_q <= pacc_next;
			mb_q   <= {mb_q[N-2:0], 1'b0};
			if (cmd.wb_base) begin
				base_q <= pacc_next;
			end
			if (cmd.wb_acc) begin
				acc_q <= pacc_next;
			end
		end
		if (cmd.exp_shift) begin
			exp_q <= {exp_q[N-2:0], 1'b0};
		end
		if (cmd.out_load) begin
			res_q <= mod_small ? '0 : acc_q;
		end
	end

	assign status.exp_bit = exp_q[N-1];
	assign power_mod      = res_q;

endmodule

`default_nettype wire

// ----- rtl/mexp_ctrl.sv -----
// Controller: sequences base reduction, squarings and multiplications, and the result handshake.
`default_nettype none

module mexp_ctrl #(
	parameter int OPERAND_BITS = 31
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	output logic                   out_valid,
	input  wire logic              out_ready,
	input  wire mexp_pkg::status_t status,
	output mexp_pkg::cmd_t         cmd
);

	localparam int CW = $clog2(OPERAND_BITS);
	localparam logic [CW-1:0] LAST = CW'(OPERAND_BITS - 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_REDUCE,
		ST_SQ_START,
		ST_SQUARE,
		ST_MUL_START,
		ST_MULT,
		ST_FINISH
	} state_t;

	state_t        state_q;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] ebit_q;
	logic          out_valid_q;
	logic          cnt_last;
	logic          ebit_last;

	assign cnt_last  = (cnt_q == LAST);
	assign ebit_last = (ebit_q == LAST);
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd     = '0;
		cmd.sel = mexp_pkg::SEL_SQUARE;
		case (state_q)
			ST_IDLE: begin
				cmd.load = in_valid;
			end
			ST_REDUCE: begin
				cmd.step    = 1'b1;
				cmd.wb_base = cnt_last;
			end
			ST_SQ_START: begin
				cmd.start = 1'b1;
				cmd.sel   = mexp_pkg::SEL_SQUARE;
			end
			ST_SQUARE: begin
				cmd.step      = 1'b1;
				cmd.wb_acc    = cnt_last;
				cmd.exp_shift = cnt_last && !status.exp_bit;
			end
			ST_MUL_START: begin
				cmd.start = 1'b1;
				cmd.sel   = mexp_pkg::SEL_MULT;
			end
			ST_MULT: begin
				cmd.step      = 1'b1;
				cmd.wb_acc    = cnt_last;
				cmd.exp_shift = cnt_last;
			end
			ST_FINISH: begin
				cmd.out_load = !out_valid_q || out_ready;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			ebit_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_FINISH && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_REDUCE;
						cnt_q   <= '0;
						ebit_q  <= '0;
					end
				end
				ST_REDUCE: begin
					if (cnt_last) begin
						cnt_q   <= '0;
						state_q <= ST_SQ_START;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_SQ_START: begin
					state_q <= ST_SQUARE;
				end
				ST_SQUARE: begin
					if (cnt_last) begin
						cnt_q <= '0;
						if (status.exp_bit) begin
							state_q <= ST_MUL_START;
						end else if (ebit_last) begin
							state_q <= ST_FINISH;
						end else begin
							ebit_q  <= ebit_q + 1'b1;
							state_q <= ST_SQ_START;
						end
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_MUL_START: begin
					state_q <= ST_MULT;
				end
				ST_MULT: begin
					if (cnt_last) begin
						cnt_q <= '0;
						if (ebit_last) begin
							state_q <= ST_FINISH;
						end else begin
							ebit_q  <= ebit_q + 1'b1;
							state_q <= ST_SQ_START;
						end
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_FINISH: begin
					if (!out_valid_q || out_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- rtl/mexp_checker.sv -----
// Port-level assertions for the modular exponentiation unit and their bind to the top level.
`default_nettype none

module mexp_checker #(
	parameter int OPERAND_BITS = 31
) (
	input wire logic                    clk,
	input wire logic                    arst_n,
	input wire logic                    in_valid,
	input wire logic                    in_ready,
	input wire logic                    out_valid,
	input wire logic                    out_ready,
	input wire logic [OPERAND_BITS-1:0] power_mod,
	input wire logic                    cfg_we,
	input wire logic [OPERAND_BITS-1:0] cfg_data
);

	logic [OPERAND_BITS-1:0] modulus_q;
	logic                    mod_small;

	// track the modulus as written at the port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q <= OPERAND_BITS'(2);
		end else if (cfg_we) begin
			modulus_q <= cfg_data;
		end
	end

	assign mod_small = (modulus_q[OPERAND_BITS-1:1] == '0);

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(power_mod))
		else $error("result item changed while stalled");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("operand item accepted while one is in progress");

	a_result_below_modulus: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !mod_small |-> power_mod < modulus_q)
		else $error("result not reduced below the modulus");

	a_result_zero_small_mod: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && mod_small |-> power_mod == '0)
		else $error("result nonzero for modulus below two");

endmodule

bind modular_exponentiation_unit mexp_checker #(
	.OPERAND_BITS(OPERAND_BITS)
) u_mexp_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (operands.valid),
	.in_ready (operands.ready),
	.out_valid(result.valid),
	.out_ready(result.ready),
	.power_mod(result.power_mod),
	.cfg_we   (cfg_we),
	.cfg_data (cfg_data)
);

`default_nettype wire
